// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: sv/dtfe_pkg.sv
// Types and constants of the DShot throttle frame encoder.
// No dependencies.
package dtfe_pkg;

	typedef enum logic [1:0] {
		FUNC_WRITE_ALL = 2'd0,
		FUNC_WRITE_ONE = 2'd1,
		FUNC_DISARM    = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		CFG_MIN_PULSE   = 2'd0,
		CFG_MAX_PULSE   = 2'd1,
		CFG_LONG_TICKS  = 2'd2,
		CFG_SHORT_TICKS = 2'd3
	} cfg_idx_t;

	localparam int CFG_W        = 12;
	localparam int VAL_W        = 11;
	localparam int FRAME_W      = 16;
	localparam int BIT_CNT_W    = 4;
	localparam int CHAN_W       = 2;
	localparam int MAX_CHANNELS = 4;
	localparam int CMD_Q_DEPTH  = 2;

	localparam logic [11:0] MIN_PULSE_RST   = 12'd1000;
	localparam logic [11:0] MAX_PULSE_RST   = 12'd2000;
	localparam logic [7:0]  LONG_TICKS_RST  = 8'd44;
	localparam logic [7:0]  SHORT_TICKS_RST = 8'd22;

	localparam logic [15:0] MAP_IN_LO    = 16'd1000;
	localparam logic [15:0] MAP_IN_HI    = 16'd2000;
	localparam logic [15:0] DISARM_BELOW = 16'd1020;
	localparam logic [15:0] ARM_GUARD    = 16'd1050;
	localparam logic [12:0] MAP_OUT_LO   = 13'd48;
	localparam logic [12:0] VAL_MAX      = 13'd2047;
	localparam logic [3:0]  CSUM_MASK    = 4'hF;

	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [CHAN_W-1:0] chan_first;
		logic [CHAN_W-1:0] chan_last;
	} cmd_t;

endpackage

// File: sv/dtfe_ifs.sv
// Handshake channels of the frame encoder: command items in, bit symbols out.
// No dependencies.
interface dtfe_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [2:0]  motor_index;
	logic [15:0] pulse_us;

	modport source(output valid, func, motor_index, pulse_us, input ready);
	modport sink(input valid, func, motor_index, pulse_us, output ready);
endinterface

interface dtfe_sym_if;
	logic       valid;
	logic       ready;
	logic [1:0] motor_channel;
	logic       frame_bit;
	logic [7:0] high_ticks;
	logic [7:0] low_ticks;
	logic       last;

	modport source(output valid, motor_channel, frame_bit, high_ticks, low_ticks, last,
		input ready);
	modport sink(input valid, motor_channel, frame_bit, high_ticks, low_ticks, last,
		output ready);
endinterface

// File: sv/dtfe_front.sv
// Front end: accepts commands, keeps the armed flag, maps pulse width to a value.
// Depends on dtfe_pkg and dtfe_ifs.
module dtfe_front #(
	parameter int NUM_MOTORS = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	dtfe_cmd_if.sink                  cmd,
	input  logic [11:0]               min_pulse_us,
	input  logic [11:0]               max_pulse_us,
	input  logic                      q_full,
	output logic                      q_push,
	output dtfe_pkg::cmd_t            q_wdata
);
	import dtfe_pkg::*;

	localparam int MOTOR_CNT = (NUM_MOTORS > MAX_CHANNELS) ? MAX_CHANNELS : NUM_MOTORS;
	localparam logic [2:0]        MOTOR_CNT_L = 3'(MOTOR_CNT);
	localparam logic [CHAN_W-1:0] CHAN_LAST   = CHAN_W'(MOTOR_CNT - 1);

	logic armed_q;
	logic armed_d;
	logic accept;
	logic [15:0] us_clamped;

	function automatic logic [VAL_W-1:0] width_to_value(input logic [15:0] us,
			input logic [11:0] lo, input logic [11:0] hi);
		logic [15:0] x;
		logic [11:0] t;
		logic [12:0] twice;
		logic [12:0] d;
		logic [2:0]  c;
		x = 16'd0;
		t = 12'd0;
		twice = 13'd0;
		d = 13'd0;
		c = 3'd0;
		if (us > {4'd0, lo}) begin
			x = (us > {4'd0, hi}) ? {4'd0, hi} : us;
			if (x >= MAP_IN_LO) begin
				t = x[11:0] - MAP_IN_LO[11:0];
				if (t == 12'd0)
					c = 3'd0;
				else if (t <= 12'd1000)
					c = 3'd1;
				else if (t <= 12'd2000)
					c = 3'd2;
				else if (t <= 12'd3000)
					c = 3'd3;
				else
					c = 3'd4;
				d = MAP_OUT_LO + {t, 1'b0} - {10'd0, c};
				if (d > VAL_MAX)
					d = VAL_MAX;
			end else begin
				t = MAP_IN_LO[11:0] - x[11:0];
				twice = {t, 1'b0};
				d = (twice >= MAP_OUT_LO + 13'd1) ? 13'd0 : MAP_OUT_LO + 13'd1 - twice;
			end
		end
		return d[VAL_W-1:0];
	endfunction

	assign cmd.ready = !q_full;
	assign accept = cmd.valid && cmd.ready;

	always_comb begin
		if (cmd.pulse_us < MAP_IN_LO)
			us_clamped = MAP_IN_LO;
		else if (cmd.pulse_us > MAP_IN_HI)
			us_clamped = MAP_IN_HI;
		else
			us_clamped = cmd.pulse_us;
	end

	always_comb begin
		q_push = 1'b0;
		armed_d = armed_q;
		q_wdata.value = '0;
		q_wdata.chan_first = '0;
		q_wdata.chan_last = CHAN_LAST;
		if (accept) begin
			case (cmd.func)
				FUNC_WRITE_ALL: begin
					q_push = 1'b1;
					if (cmd.pulse_us < DISARM_BELOW) begin
						armed_d = 1'b0;
					end else begin
						armed_d = 1'b1;
						q_wdata.value = width_to_value(cmd.pulse_us, min_pulse_us, max_pulse_us);
					end
				end
				FUNC_WRITE_ONE: begin
					if (cmd.motor_index < MOTOR_CNT_L) begin
						q_push = 1'b1;
						q_wdata.chan_first = cmd.motor_index[CHAN_W-1:0];
						q_wdata.chan_last = cmd.motor_index[CHAN_W-1:0];
						if (armed_q || us_clamped >= ARM_GUARD)
							q_wdata.value = width_to_value(us_clamped, min_pulse_us,
								max_pulse_us);
					end
				end
				FUNC_DISARM: begin
					q_push = 1'b1;
					armed_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			armed_q <= 1'b0;
		else
			armed_q <= armed_d;
	end

endmodule

// File: sv/dtfe_cmd_fifo.sv
// Short command queue between the front end and the symbol serializer.
// Depends on dtfe_pkg.
module dtfe_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dtfe_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output dtfe_pkg::cmd_t rdata,
	output logic           empty
);
	import dtfe_pkg::*;

	localparam int PTR_W = $clog2(CMD_Q_DEPTH);
	localparam int CNT_W = $clog2(CMD_Q_DEPTH + 1);

	cmd_t             mem_q [CMD_Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(CMD_Q_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: sv/dtfe_back.sv
// Back end: builds the 16-bit frame with checksum and sends it one bit symbol a cycle while sym.ready is high.
// Depends on dtfe_pkg and dtfe_ifs.
module dtfe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  dtfe_pkg::cmd_t q_rdata,
	output logic           q_pop,
	input  logic [7:0]     long_ticks,
	input  logic [7:0]     short_ticks,
	dtfe_sym_if.source     sym
);
	import dtfe_pkg::*;

	logic                 busy_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [CHAN_W-1:0]    chan_q;
	logic [CHAN_W-1:0]    chan_last_q;
	logic [BIT_CNT_W-1:0] bit_q;
	logic                 sym_valid_q;
	logic [CHAN_W-1:0]    sym_chan_q;
	logic                 sym_bit_q;
	logic [7:0]           sym_high_q;
	logic [7:0]           sym_low_q;
	logic                 sym_last_q;

	logic [VAL_W:0]       pkt;
	logic [3:0]           csum;
	logic                 adv;
	logic                 cur_bit;
	logic                 frame_end;

	assign pkt  = {q_rdata.value, 1'b0};
	assign csum = (pkt[3:0] ^ pkt[7:4] ^ pkt[11:8]) & CSUM_MASK;

	assign q_pop     = !busy_q && !q_empty;
	assign adv       = busy_q && (!sym_valid_q || sym.ready);
	assign cur_bit   = frame_q[BIT_CNT_W'(FRAME_W - 1) - bit_q];
	assign frame_end = (bit_q == BIT_CNT_W'(FRAME_W - 1));

	assign sym.valid         = sym_valid_q;
	assign sym.motor_channel = sym_chan_q;
	assign sym.frame_bit     = sym_bit_q;
	assign sym.high_ticks    = sym_high_q;
	assign sym.low_ticks     = sym_low_q;
	assign sym.last          = sym_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			sym_valid_q <= 1'b0;
			bit_q       <= '0;
			chan_q      <= '0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
				chan_q <= q_rdata.chan_first;
			end else if (adv) begin
				bit_q <= bit_q + 1'b1;
				if (frame_end) begin
					if (chan_q == chan_last_q)
						busy_q <= 1'b0;
					else
						chan_q <= chan_q + 1'b1;
				end
			end
			if (adv)
				sym_valid_q <= 1'b1;
			else if (sym.ready)
				sym_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			frame_q     <= {q_rdata.value, 1'b0, csum};
			chan_last_q <= q_rdata.chan_last;
		end
		if (adv) begin
			sym_chan_q <= chan_q;
			sym_bit_q  <= cur_bit;
			sym_high_q <= cur_bit ? long_ticks : short_ticks;
			sym_low_q  <= cur_bit ? short_ticks : long_ticks;
			sym_last_q <= frame_end && (chan_q == chan_last_q);
		end
	end

endmodule

// File: sv/dshot_throttle_frame_encoder_top.sv
// Path: an accepted command is written into the queue, popped into the serializer once it is idle,
// and each bit symbol is registered into the output register. Throughput: one bit symbol per
// cycle within a command while the receiver is ready, 16 per motor frame; a two-entry queue holds the next commands.
// Reset: armed cleared, queue empty, output idle, registers back to 1000/2000/44/22.
// Depends on dtfe_pkg, dtfe_ifs, dtfe_front, dtfe_cmd_fifo, dtfe_back, assert_macros.svh.
module dshot_throttle_frame_encoder_top #(
	parameter int NUM_MOTORS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_wdata,
	dtfe_cmd_if.sink    cmd,
	dtfe_sym_if.source  sym
);
	import dtfe_pkg::*;
	`include "assert_macros.svh"

	localparam int MOTOR_CNT = (NUM_MOTORS > MAX_CHANNELS) ? MAX_CHANNELS : NUM_MOTORS;
	localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(MOTOR_CNT - 1);

	logic [11:0] min_pulse_q;
	logic [11:0] max_pulse_q;
	logic [7:0]  long_ticks_q;
	logic [7:0]  short_ticks_q;

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	cmd_t q_wdata;
	cmd_t q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q   <= MIN_PULSE_RST;
			max_pulse_q   <= MAX_PULSE_RST;
			long_ticks_q  <= LONG_TICKS_RST;
			short_ticks_q <= SHORT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_PULSE:   min_pulse_q   <= cfg_wdata;
				CFG_MAX_PULSE:   max_pulse_q   <= cfg_wdata;
				CFG_LONG_TICKS:  long_ticks_q  <= cfg_wdata[7:0];
				CFG_SHORT_TICKS: short_ticks_q <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	dtfe_front #(
		.NUM_MOTORS(NUM_MOTORS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.min_pulse_us(min_pulse_q),
		.max_pulse_us(max_pulse_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_wdata     (q_wdata)
	);

	dtfe_cmd_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	dtfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.long_ticks (long_ticks_q),
		.short_ticks(short_ticks_q),
		.sym        (sym)
	);

	`ASSERT_NEVER(a_push_full, q_push && q_full, "command pushed into full queue")
	`ASSERT_NEVER(a_pop_empty, q_pop && q_empty, "command popped from empty queue")
	`ASSERT_CLK(a_chan_range, sym.valid |-> sym.motor_channel <= CHAN_LAST, "channel out of range")

endmodule

// File: sim/tb_dshot_throttle_frame_encoder_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of dshot_throttle_frame_encoder_top: predicts every bit symbol
// of each command item and compares it field by field under random idling and stalls.
// Depends on dtfe_pkg, dtfe_ifs and the encoder RTL.
module tb_dshot_throttle_frame_encoder_top;
	import dtfe_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int         MOTORS       = 4;
	localparam int         DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [1:0] chan;
		logic       frame_bit;
		logic [7:0] high;
		logic [7:0] low;
		logic       last;
	} symbol_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_wdata;

	dtfe_cmd_if cmd();
	dtfe_sym_if sym();

	dshot_throttle_frame_encoder_top #(.NUM_MOTORS(MOTORS)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.sym      (sym)
	);

	// encoder state mirrored by the predictor
	logic [11:0] min_us;
	logic [11:0] max_us;
	logic [7:0]  long_t;
	logic [7:0]  short_t;
	logic        armed;

	symbol_t pending_symbols[$];
	symbol_t exp_sym;
	int      failures;
	int      send_idle_pct;
	int      recv_idle_pct;
	int      hold_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [10:0] throttle_value(logic [15:0] us);
		int x;
		int d;
		if (us <= min_us)
			return 11'd0;
		x = int'(us);
		if (x > int'(max_us))
			x = int'(max_us);
		if (x >= 1000)
			d = ((x - 1000) * 1999) / 1000 + 48;
		else
			d = 48 - ((1000 - x) * 1999) / 1000;
		if (d < 0)
			d = 0;
		if (d > 2047)
			d = 2047;
		return d[10:0];
	endfunction

	task automatic queue_frame(logic [1:0] chan, logic [10:0] value, logic last_frame);
		logic [11:0] pkt;
		logic [15:0] frame;
		symbol_t     s;
		pkt   = {value, 1'b0};
		frame = {pkt, pkt[3:0] ^ pkt[7:4] ^ pkt[11:8]};
		for (int i = 15; i >= 0; i--) begin
			s.chan      = chan;
			s.frame_bit = frame[i];
			s.high      = frame[i] ? long_t : short_t;
			s.low       = frame[i] ? short_t : long_t;
			s.last      = last_frame && (i == 0);
			pending_symbols.push_back(s);
		end
	endtask

	task automatic queue_all_motors(logic [10:0] value);
		for (int c = 0; c < MOTORS; c++)
			queue_frame(c[1:0], value, c == MOTORS - 1);
	endtask

	task automatic predict_command(logic [1:0] f, logic [2:0] idx, logic [15:0] us);
		logic [15:0] w;
		case (f)
			FUNC_WRITE_ALL: begin
				if (us < 16'd1020) begin
					armed = 1'b0;
					queue_all_motors(11'd0);
				end else begin
					queue_all_motors(throttle_value(us));
					armed = 1'b1;
				end
			end
			FUNC_WRITE_ONE: begin
				if (idx < MOTORS) begin
					w = us < 16'd1000 ? 16'd1000 : (us > 16'd2000 ? 16'd2000 : us);
					if (!armed && w < 16'd1050)
						queue_frame(idx[1:0], 11'd0, 1'b1);
					else
						queue_frame(idx[1:0], throttle_value(w), 1'b1);
				end
			end
			FUNC_DISARM: begin
				armed = 1'b0;
				queue_all_motors(11'd0);
			end
			default: ;
		endcase
	endtask

	task automatic send_command(logic [1:0] f, logic [2:0] idx, logic [15:0] us);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid = 1'b0;
			@(negedge clk);
		end
		cmd.func        = f;
		cmd.motor_index = idx;
		cmd.pulse_us    = us;
		cmd.valid       = 1'b1;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		predict_command(f, idx, us);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		cmd.valid = 1'b0;
		while (pending_symbols.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [11:0] v);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_MIN_PULSE:   min_us  = v;
			CFG_MAX_PULSE:   max_us  = v;
			CFG_LONG_TICKS:  long_t  = v[7:0];
			CFG_SHORT_TICKS: short_t = v[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [11:0] lo, logic [11:0] hi, logic [7:0] lt, logic [7:0] st);
		wait_idle();
		write_reg(CFG_MIN_PULSE, lo);
		write_reg(CFG_MAX_PULSE, hi);
		write_reg(CFG_LONG_TICKS, {4'd0, lt});
		write_reg(CFG_SHORT_TICKS, {4'd0, st});
	endtask

	function automatic logic [15:0] random_pulse();
		case ($urandom_range(9))
			0: return 16'($urandom_range(65535, 0));
			1: return 16'($urandom_range(1100, 0));
			2: begin
				case ($urandom_range(7))
					0: return {4'd0, min_us};
					1: return {4'd0, min_us} + 16'd1;
					2: return {4'd0, max_us};
					3: return {4'd0, max_us} + 16'd1;
					4: return 16'd1019;
					5: return 16'd1020;
					6: return 16'd1049;
					default: return 16'd1050;
				endcase
			end
			default: return 16'($urandom_range(2150, 950));
		endcase
	endfunction

	// defaults after reset, disarmed and armed write-one guard, ignored items
	task automatic test_reset_defaults();
		send_command(FUNC_WRITE_ONE, 3'd0, 16'd1049);
		send_command(FUNC_WRITE_ONE, 3'd1, 16'd1050);
		send_command(FUNC_WRITE_ONE, 3'd2, 16'd0);
		send_command(FUNC_WRITE_ONE, 3'd3, 16'hFFFF);
		send_command(FUNC_WRITE_ONE, 3'd4, 16'd1500);
		send_command(FUNC_WRITE_ONE, 3'd7, 16'd1500);
		send_command(FUNC_UNUSED, 3'd0, 16'd1500);
		send_command(FUNC_WRITE_ALL, 3'd0, 16'd1019);
		send_command(FUNC_WRITE_ALL, 3'd5, 16'd1020);
		send_command(FUNC_WRITE_ONE, 3'd0, 16'd1000);
		send_command(FUNC_WRITE_ONE, 3'd1, 16'd1049);
		send_command(FUNC_WRITE_ONE, 3'd3, 16'd2000);
		send_command(FUNC_WRITE_ALL, 3'd0, 16'hFFFF);
		send_command(FUNC_WRITE_ALL, 3'd0, 16'd1500);
		send_command(FUNC_DISARM, 3'd7, 16'd2000);
		send_command(FUNC_WRITE_ONE, 3'd2, 16'd1001);
	endtask

	task automatic test_register_extremes();
		set_config(12'd0, 12'd4095, 8'd255, 8'd1);
		send_command(FUNC_WRITE_ALL, 3'd0, 16'd1020);
		send_command(FUNC_WRITE_ALL, 3'd0, 16'd4095);
		send_command(FUNC_WRITE_ONE, 3'd3, 16'd1000);
		send_command(FUNC_DISARM, 3'd0, 16'd0);
		send_command(FUNC_WRITE_ONE, 3'd0, 16'd1020);
		set_config(12'd4095, 12'd0, 8'd1, 8'd255);
		send_command(FUNC_WRITE_ALL, 3'd0, 16'd1020);
		send_command(FUNC_WRITE_ALL, 3'd0, 16'hFFFF);
		send_command(FUNC_WRITE_ONE, 3'd1, 16'd2000);
	endtask

	// min above max, and a max below 1000 that clamps inputs onto the map's lower branch
	task automatic test_crossed_bounds();
		set_config(12'd3000, 12'd990, 8'd44, 8'd22);
		send_command(FUNC_WRITE_ALL, 3'd0, 16'd3001);
		send_command(FUNC_WRITE_ALL, 3'd0, 16'd2000);
		send_command(FUNC_WRITE_ONE, 3'd2, 16'd2000);
		set_config(12'd500, 12'd990, 8'd44, 8'd22);
		send_command(FUNC_WRITE_ALL, 3'd0, 16'd1500);
		send_command(FUNC_WRITE_ONE, 3'd1, 16'd1000);
	endtask

	task automatic test_random_traffic(int n);
		logic [1:0] f;
		logic [2:0] idx;
		int         r;
		int         done;
		done = 0;
		while (done < n) begin
			r   = $urandom_range(99);
			idx = 3'($urandom_range(7, 0));
			if (r < 40)
				f = FUNC_WRITE_ALL;
			else if (r < 78) begin
				f = FUNC_WRITE_ONE;
				if ($urandom_range(9) != 0)
					idx = 3'($urandom_range(3, 0));
			end else if (r < 92)
				f = FUNC_DISARM;
			else
				f = FUNC_UNUSED;
			send_command(f, idx, random_pulse());
			if (f != FUNC_UNUSED && !(f == FUNC_WRITE_ONE && idx >= MOTORS))
				done++;
		end
	endtask

	// receiver stalls long enough for the command queue to fill
	task automatic test_backpressure();
		wait_idle();
		hold_cycles = 400;
		for (int i = 0; i < 8; i++)
			send_command(FUNC_WRITE_ALL, 3'd0, random_pulse());
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			sym.ready   = 1'b0;
			hold_cycles = hold_cycles - 1;
		end else
			sym.ready = ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && sym.valid && sym.ready) begin
			if (pending_symbols.size() == 0) begin
				$error("unexpected symbol: chan %0d bit %0d", sym.motor_channel, sym.frame_bit);
				failures++;
			end else begin
				exp_sym = pending_symbols.pop_front();
				if (sym.motor_channel !== exp_sym.chan) begin
					$error("motor_channel: expected %0d, got %0d", exp_sym.chan,
						sym.motor_channel);
					failures++;
				end
				if (sym.frame_bit !== exp_sym.frame_bit) begin
					$error("frame_bit: expected %0d, got %0d", exp_sym.frame_bit,
						sym.frame_bit);
					failures++;
				end
				if (sym.high_ticks !== exp_sym.high) begin
					$error("high_ticks: expected %0d, got %0d", exp_sym.high,
						sym.high_ticks);
					failures++;
				end
				if (sym.low_ticks !== exp_sym.low) begin
					$error("low_ticks: expected %0d, got %0d", exp_sym.low, sym.low_ticks);
					failures++;
				end
				if (sym.last !== exp_sym.last) begin
					$error("last: expected %0d, got %0d", exp_sym.last, sym.last);
					failures++;
				end
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_MIN_PULSE;
		cfg_wdata       = 12'd0;
		cmd.valid       = 1'b0;
		cmd.func        = FUNC_WRITE_ALL;
		cmd.motor_index = 3'd0;
		cmd.pulse_us    = 16'd0;
		sym.ready       = 1'b0;
		failures        = 0;
		hold_cycles     = 0;
		send_idle_pct   = 8;
		recv_idle_pct   = 72;
		min_us          = 12'd1000;
		max_us          = 12'd2000;
		long_t          = 8'd44;
		short_t         = 8'd22;
		armed           = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_crossed_bounds();
		set_config(12'd900, 12'd2100, 8'd44, 8'd22);
		test_random_traffic(58);

		wait_idle();
		send_idle_pct = 72;
		recv_idle_pct = 8;
		set_config(12'd1000, 12'd2000, 8'd30, 8'd15);
		test_random_traffic(58);

		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(12'd1000, 12'd2000, 8'd44, 8'd22);
		test_random_traffic(57);
		test_backpressure();

		wait_idle();
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/dtfe_pkg.sv
sv/dtfe_ifs.sv
sv/dtfe_front.sv
sv/dtfe_cmd_fifo.sv
sv/dtfe_back.sv
sv/dshot_throttle_frame_encoder_top.sv
sim/tb_dshot_throttle_frame_encoder_top.sv
